[rtl/core/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, case codes and control types for the bounding sphere merge.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned W      = 32;  // field width, Q16.16
  localparam int unsigned MAG_W  = 33;  // magnitude of a centre difference
  localparam int unsigned ACC_W  = 68;  // squared distance accumulator
  localparam int unsigned DIST_W = 34;  // floor square root of the accumulator
  localparam int unsigned SUM_W  = 35;  // distance plus radii
  localparam int unsigned Q_W    = 33;  // unsigned Q1.32 ratio
  localparam int unsigned SQRT_STEPS = ACC_W / 2;
  localparam int unsigned DIV_STEPS  = Q_W;

  // merge case codes
  localparam logic [2:0] CASE_EMPTY   = 3'd0;
  localparam logic [2:0] CASE_COPIED  = 3'd1;
  localparam logic [2:0] CASE_CONC    = 3'd2;
  localparam logic [2:0] CASE_IN_KEPT = 3'd3;
  localparam logic [2:0] CASE_KEPT_IN = 3'd4;
  localparam logic [2:0] CASE_GROWN   = 3'd5;

  // multiply-accumulate control
  typedef struct packed {
    logic en;   // perform one partial product
    logic clr;  // start a new sum
    logic hi;   // upper half of the b operand
  } mac_ctrl_t;

  // magnitude of a 33-bit signed difference
  function automatic logic [MAG_W-1:0] mag33(input logic signed [MAG_W-1:0] v);
    mag33 = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

[rtl/core/bsm_if.sv]
// ----------------------------------------------------------------------------
// bsm_if
// Valid/ready channels carrying input spheres and merged results.
// ----------------------------------------------------------------------------
interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  logic [31:0] in_radius;
  logic [31:0] in_max_radius;
  modport source (output valid, in_x, in_y, in_z, in_radius, in_max_radius, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_radius, in_max_radius, output ready);
endinterface

interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_radius;
  logic [31:0] out_max_radius;
  logic [2:0]  merge_case;
  modport source (output valid, out_x, out_y, out_z, out_radius, out_max_radius,
                  merge_case, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_radius, out_max_radius,
                  merge_case, output ready);
endinterface

[rtl/core/bounding_sphere_merge_core.sv]
// Sequence: an empty input or an empty kept sphere goes straight to the result;
// other spheres take the squared distance, the 34-step square root and the
// classification, and a grown sphere then the 33-step divide and centre shift.
// One sphere at a time: the next is taken once the result is loaded.
// Reset: synchronous active-low rst_n clears the kept sphere to empty, all zero.
// ----------------------------------------------------------------------------
// bounding_sphere_merge_core
// Running bounding sphere union with a shared multiplier and iterative units.
// ----------------------------------------------------------------------------
module bounding_sphere_merge_core (
  input  logic         clk,
  input  logic         rst_n,
  bsm_in_if.sink       in_bus,
  bsm_out_if.source    out_bus
);
  import bsm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_RSTART = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_CLASS  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_SH     = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [1:0] ph_r, ph_nxt;

  // kept sphere
  logic [W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [W-1:0] rad_r, rad_nxt, loose_r, loose_nxt;
  logic [2:0]   code_r, code_nxt;

  // current beat
  logic [W-1:0] ix_r, ix_nxt, iy_r, iy_nxt, iz_r, iz_nxt, r2_r, r2_nxt;
  logic signed [MAG_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  // result register
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] ox_r, oy_r, oz_r, orad_r, oloose_r;
  logic [2:0]   ocase_r;
  logic         out_load;

  // shared units
  mac_ctrl_t         mac_ctrl;
  logic [MAG_W-1:0]  mac_a, mac_b;
  logic [ACC_W-1:0]  mac_acc;
  logic              sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;
  logic              dv_start, dv_done;
  logic [Q_W-1:0]    dv_q;
  logic [SUM_W-1:0]  dv_num, dv_den;

  logic              in_acc;
  logic signed [MAG_W-1:0] dsel;
  logic [W-1:0]      csel, cnew;
  logic [W-1:0]      off;
  logic [SUM_W-1:0]  d_r2, d_r1, d_sum;

  assign in_acc       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  // axis selection for the multiplier and the centre update
  always_comb begin
    unique case (ax_r)
      2'd0:    begin dsel = dx_r; csel = cx_r; end
      2'd1:    begin dsel = dy_r; csel = cy_r; end
      default: begin dsel = dz_r; csel = cz_r; end
    endcase
  end

  assign mac_a = mag33(dsel);
  assign mac_b = (state_r == S_SH) ? dv_q : mag33(dsel);
  assign mac_ctrl.en  = ((state_r == S_SQ) || (state_r == S_SH)) && (ph_r != 2'd2);
  assign mac_ctrl.clr = (state_r == S_SQ) ? (ax_r == 2'd0 && ph_r == 2'd0)
                                          : (ph_r == 2'd0);
  assign mac_ctrl.hi  = ph_r[0];

  // offset along one axis, truncated toward zero; never above the difference
  assign off  = mac_acc[63:32];
  assign cnew = dsel[MAG_W-1] ? W'({1'b0, csel} - {1'b0, off})
                              : W'({1'b0, csel} + {1'b0, off});

  // classification sums
  assign d_r2  = SUM_W'(dist_r) + SUM_W'(r2_r);
  assign d_r1  = SUM_W'(dist_r) + SUM_W'(rad_r);
  assign d_sum = d_r1 + SUM_W'(r2_r);
  assign dv_num = d_r2 - SUM_W'(rad_r);
  assign dv_den = {dist_r, 1'b0};
  assign sq_start = (state_r == S_RSTART);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  // sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    ph_nxt    = ph_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    rad_nxt   = rad_r;
    loose_nxt = loose_r;
    code_nxt  = code_r;
    ix_nxt    = ix_r;
    iy_nxt    = iy_r;
    iz_nxt    = iz_r;
    r2_nxt    = r2_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    dz_nxt    = dz_r;
    dist_nxt  = dist_r;
    dv_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ix_nxt = in_bus.in_x;
          iy_nxt = in_bus.in_y;
          iz_nxt = in_bus.in_z;
          r2_nxt = in_bus.in_radius;
          dx_nxt = $signed({in_bus.in_x[W-1], in_bus.in_x}) - $signed({cx_r[W-1], cx_r});
          dy_nxt = $signed({in_bus.in_y[W-1], in_bus.in_y}) - $signed({cy_r[W-1], cy_r});
          dz_nxt = $signed({in_bus.in_z[W-1], in_bus.in_z}) - $signed({cz_r[W-1], cz_r});
          if (loose_r < in_bus.in_max_radius) loose_nxt = in_bus.in_max_radius;
          ax_nxt = 2'd0;
          ph_nxt = 2'd0;
          priority if (in_bus.in_radius == '0) begin
            code_nxt  = CASE_EMPTY;
            state_nxt = S_DONE;
          end else if (rad_r == '0) begin
            cx_nxt    = in_bus.in_x;
            cy_nxt    = in_bus.in_y;
            cz_nxt    = in_bus.in_z;
            rad_nxt   = in_bus.in_radius;
            loose_nxt = in_bus.in_max_radius;
            code_nxt  = CASE_COPIED;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        // two partial products per axis into one sum
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = 2'd0;
          ax_nxt = ax_r + 2'd1;
          if (ax_r == 2'd2) state_nxt = S_RSTART;
        end
      end
      S_RSTART: state_nxt = S_ROOT;
      S_ROOT: begin
        if (sq_done) begin
          dist_nxt  = sq_root;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (dist_r == '0) begin
          if (r2_r > rad_r) rad_nxt = r2_r;
          code_nxt  = CASE_CONC;
          state_nxt = S_DONE;
        end else if (SUM_W'(rad_r) > d_r2) begin
          code_nxt  = CASE_IN_KEPT;
          state_nxt = S_DONE;
        end else if (d_r1 < SUM_W'(r2_r)) begin
          cx_nxt    = ix_r;
          cy_nxt    = iy_r;
          cz_nxt    = iz_r;
          rad_nxt   = r2_r;
          code_nxt  = CASE_KEPT_IN;
          state_nxt = S_DONE;
        end else begin
          rad_nxt   = (d_sum[SUM_W-1:1] > (SUM_W-1)'({W{1'b1}})) ? {W{1'b1}}
                                                                  : d_sum[W:1];
          code_nxt  = CASE_GROWN;
          dv_start  = 1'b1;
          ax_nxt    = 2'd0;
          ph_nxt    = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done) state_nxt = S_SH;
      end
      S_SH: begin
        // low half, high half, then apply the offset
        if (ph_r != 2'd2) begin
          ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          ax_nxt = ax_r + 2'd1;
          unique case (ax_r)
            2'd0:    cx_nxt = cnew;
            2'd1:    cy_nxt = cnew;
            default: cz_nxt = cnew;
          endcase
          if (ax_r == 2'd2) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      ph_r        <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      rad_r       <= '0;
      loose_r     <= '0;
      code_r      <= CASE_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      ph_r        <= ph_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
      rad_r       <= rad_nxt;
      loose_r     <= loose_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ix_r   <= ix_nxt;
    iy_r   <= iy_nxt;
    iz_r   <= iz_nxt;
    r2_r   <= r2_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    dist_r <= dist_nxt;
    if (out_load) begin
      ox_r     <= cx_r;
      oy_r     <= cy_r;
      oz_r     <= cz_r;
      orad_r   <= rad_r;
      oloose_r <= loose_r;
      ocase_r  <= code_r;
    end
  end

  bsm_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (mac_acc)
  );

  bsm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mac_acc),
    .root     (sq_root),
    .done     (sq_done)
  );

  bsm_fdiv u_fdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .quot  (dv_q),
    .done  (dv_done)
  );

  assign out_bus.valid          = out_valid_r;
  assign out_bus.out_x          = ox_r;
  assign out_bus.out_y          = oy_r;
  assign out_bus.out_z          = oz_r;
  assign out_bus.out_radius     = orad_r;
  assign out_bus.out_max_radius = oloose_r;
  assign out_bus.merge_case     = ocase_r;

  // a valid result carries a defined case code
  a_case_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.merge_case <= CASE_GROWN))
    else $error("merge case code out of range");

  // the root only completes while the sequencer waits for it
  a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_ROOT))
    else $error("square root finished outside its wait state");

  // the quotient only completes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == S_DIV))
    else $error("divide finished outside its wait state");

  // a grown or copied sphere is never left empty
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (code_r == CASE_GROWN || code_r == CASE_COPIED)) |-> (rad_r != '0))
    else $error("merged sphere empty after growth or copy");

endmodule

[rtl/core/bsm_mac.sv]
// ----------------------------------------------------------------------------
// bsm_mac
// Shared 33x17 multiply-accumulate; a full 33x33 product takes two steps.
// ----------------------------------------------------------------------------
module bsm_mac (
  input  logic                       clk,
  input  bsm_pkg::mac_ctrl_t         ctrl,
  input  logic [bsm_pkg::MAG_W-1:0]  a,
  input  logic [bsm_pkg::MAG_W-1:0]  b,
  output logic [bsm_pkg::ACC_W-1:0]  acc
);
  import bsm_pkg::*;

  logic [16:0]      mul_b;
  logic [49:0]      prod;
  logic [ACC_W-1:0] part;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;

  // select half of b, multiply, align
  assign mul_b = ctrl.hi ? {1'b0, b[32:17]} : b[16:0];
  assign prod  = 50'(a) * 50'(mul_b);
  assign part  = ctrl.hi ? ACC_W'({prod, 17'b0}) : ACC_W'(prod);
  assign acc_nxt = ctrl.clr ? part : acc_r + part;

  always_ff @(posedge clk) begin
    if (ctrl.en) acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[rtl/core/bsm_isqrt.sv]
// ----------------------------------------------------------------------------
// bsm_isqrt
// Floor square root of a 68-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bsm_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsm_pkg::ACC_W-1:0]   radicand,
  output logic [bsm_pkg::DIST_W-1:0]  root,
  output logic                        done
);
  import bsm_pkg::*;

  localparam int unsigned REM_W = DIST_W + 4;
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);

  logic [ACC_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [DIST_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // one restoring step
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[ACC_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[ACC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[DIST_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

[rtl/core/bsm_fdiv.sv]
// ----------------------------------------------------------------------------
// bsm_fdiv
// Restoring fraction divide num/den as unsigned Q1.32, one bit per cycle.
// ----------------------------------------------------------------------------
module bsm_fdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsm_pkg::SUM_W-1:0]   num,
  input  logic [bsm_pkg::SUM_W-1:0]   den,
  output logic [bsm_pkg::Q_W-1:0]     quot,
  output logic                        done
);
  import bsm_pkg::*;

  localparam int unsigned REM_W = SUM_W + 1;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   q_r,   q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] rem_sh;

  // first step compares without shifting
  assign rem_sh = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = REM_W'(num);
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= REM_W'(den_r)) begin
        rem_nxt = rem_sh - REM_W'(den_r);
        q_nxt   = {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the running bounding sphere union: a directed table of spheres and
// then random spheres, each merge result compared against a local predictor,
// under several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
  import bsm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bsm_in_if  in_bus ();
  bsm_out_if out_bus ();

  bounding_sphere_merge_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] x, y, z, rad, maxr;
  } sphere_t;

  typedef struct packed {
    logic [31:0] x, y, z, rad, maxr;
    logic [2:0]  mcase;
  } merged_t;

  // predictor state: the kept sphere and loose bound
  logic signed [63:0] kept_x, kept_y, kept_z;
  logic [63:0]        kept_rad, kept_loose;

  merged_t expected_merges[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic logic [63:0] floor_sqrt(input logic [67:0] v);
    logic [69:0] rem;
    logic [69:0] trial;
    logic [35:0] root;
    rem = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[34:0], 1'b1};
      end else begin
        root = {root[34:0], 1'b0};
      end
    end
    return 64'(root);
  endfunction

  function automatic logic [63:0] ratio_q132(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q = '0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem = rem - den;
    end
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] move_axis(input logic signed [63:0] c,
                                                   input logic signed [63:0] delta,
                                                   input logic [63:0] t);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = delta < 0 ? 64'(-delta) : 64'(delta);
    prod = mag * t;
    return delta < 0 ? c - $signed(prod[95:32]) : c + $signed(prod[95:32]);
  endfunction

  // merge one sphere into the predicted state
  function automatic merged_t merge_sphere(input sphere_t s);
    logic signed [63:0] ix, iy, iz, dx, dy, dz;
    logic [63:0]  mx, my, mz;
    logic [63:0]  r1, r2, dist_v, t, nr;
    logic [67:0]  sq;
    logic [2:0]   mcase;
    merged_t      m;
    ix = 64'($signed(s.x));
    iy = 64'($signed(s.y));
    iz = 64'($signed(s.z));
    r2 = 64'(s.rad);
    if (kept_loose < 64'(s.maxr)) kept_loose = 64'(s.maxr);
    if (r2 == 0) begin
      mcase = CASE_EMPTY;
    end else if (kept_rad == 0) begin
      kept_x = ix; kept_y = iy; kept_z = iz;
      kept_rad = r2;
      kept_loose = 64'(s.maxr);
      mcase = CASE_COPIED;
    end else begin
      dx = ix - kept_x; dy = iy - kept_y; dz = iz - kept_z;
      mx = dx < 0 ? 64'(-dx) : 64'(dx);
      my = dy < 0 ? 64'(-dy) : 64'(dy);
      mz = dz < 0 ? 64'(-dz) : 64'(dz);
      r1 = kept_rad;
      sq = 68'(mx * mx) + 68'(my * my) + 68'(mz * mz);
      dist_v = floor_sqrt(sq);
      if (dist_v == 0) begin
        kept_rad = r2 > r1 ? r2 : r1;
        mcase = CASE_CONC;
      end else if (r1 > dist_v + r2) begin
        mcase = CASE_IN_KEPT;
      end else if (dist_v + r1 < r2) begin
        kept_x = ix; kept_y = iy; kept_z = iz;
        kept_rad = r2;
        mcase = CASE_KEPT_IN;
      end else begin
        t = ratio_q132(dist_v + r2 - r1, dist_v << 1);
        nr = (dist_v + r1 + r2) >> 1;
        kept_x = move_axis(kept_x, dx, t);
        kept_y = move_axis(kept_y, dy, t);
        kept_z = move_axis(kept_z, dz, t);
        kept_rad = nr > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : nr;
        mcase = CASE_GROWN;
      end
    end
    m.x = kept_x[31:0];
    m.y = kept_y[31:0];
    m.z = kept_z[31:0];
    m.rad = kept_rad[31:0];
    m.maxr = kept_loose[31:0];
    m.mcase = mcase;
    return m;
  endfunction

  // send one beat; expectation queued on acceptance
  task automatic send_sphere(input sphere_t s, input bit typed, input merged_t want);
    merged_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_x <= s.x;
    in_bus.in_y <= s.y;
    in_bus.in_z <= s.z;
    in_bus.in_radius <= s.rad;
    in_bus.in_max_radius <= s.maxr;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    m = merge_sphere(s);
    if (typed && m != want) begin
      $display("%0t table row disagrees with predictor: table %h predictor %h",
               $time, want, m);
      errors++;
    end
    expected_merges.push_back(m);
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    merged_t got;
    merged_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.out_radius,
             out_bus.out_max_radius, out_bus.merge_case};
      if (expected_merges.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = expected_merges.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom;
      2: return 32'($urandom_range(500)) << 16;
      3: return 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: return 32'($urandom_range(1 << 22));
    endcase
  endfunction

  typedef struct {
    sphere_t s;
    bit      typed;
    merged_t want;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    sphere_t    s;
    merged_t    none;
    none = '0;
    in_bus.valid = 1'b0;
    in_bus.in_x = '0;
    in_bus.in_y = '0;
    in_bus.in_z = '0;
    in_bus.in_radius = '0;
    in_bus.in_max_radius = '0;
    out_bus.ready = 1'b0;
    kept_x = 0; kept_y = 0; kept_z = 0; kept_rad = 0; kept_loose = 0;

    // directed table; results typed in where obvious
    rows.push_back('{'{32'h1, 32'h2, 32'h3, 32'h0, 32'h0005_0000}, 1,
                     '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0000, CASE_EMPTY}});
    rows.push_back('{'{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000}, 1,
                     '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000,
                       CASE_COPIED}});
    rows.push_back('{'{32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0}, 1,
                     '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0002_0000,
                       CASE_CONC}});
    rows.push_back('{'{32'h0001_8000, 32'h0, 32'h0, 32'h0000_8000, 32'h0}, 1,
                     '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0002_0000,
                       CASE_IN_KEPT}});
    rows.push_back('{'{32'h0002_0000, 32'h0, 32'h0, 32'h000A_0000, 32'hFFFF_FFFF}, 1,
                     '{32'h0002_0000, 32'h0, 32'h0, 32'h000A_0000, 32'hFFFF_FFFF,
                       CASE_KEPT_IN}});
    rows.push_back('{'{32'h0012_0000, 32'h0, 32'h0, 32'h000A_0000, 32'h0}, 1,
                     '{32'h000A_0000, 32'h0, 32'h0, 32'h0012_0000, 32'hFFFF_FFFF,
                       CASE_GROWN}});
    rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h0}, 0, none});
    rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'h0}, 0, none});
    rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h1, 32'h1}, 0, none});
    rows.push_back('{'{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'h0}, 0, none});
    rows.push_back('{'{32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'h8000_0000,
                       32'h7FFF_FFFF}, 0, none});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_sphere(rows[i].s, rows[i].typed, rows[i].want);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 14 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 14 : 0;
      for (int n = 0; n < 160; n++) begin
        s.x = rand_coord();
        s.y = rand_coord();
        s.z = rand_coord();
        s.rad = rand_radius();
        s.maxr = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 20));
        // nearby centres often, to reach containment and concentric cases
        if ($urandom_range(3) == 0) begin
          s.x = kept_x[31:0] + 32'($urandom_range(3));
          s.y = kept_y[31:0];
          s.z = kept_z[31:0];
        end
        send_sphere(s, 1'b0, none);
      end
    end
    in_bus.valid <= 1'b0;

    while (expected_merges.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bsm_pkg.sv
rtl/core/bsm_if.sv
rtl/core/bsm_mac.sv
rtl/core/bsm_isqrt.sv
rtl/core/bsm_fdiv.sv
rtl/core/bounding_sphere_merge_core.sv
tb/sv/testbench.sv
